// ===== design/tcce_pkg.sv =====
// Shared constants, types and helpers for the text console cursor engine.
// No dependencies; used by tcce_scroll_unit and text_console_cursor_engine_top.
package tcce_pkg;

  localparam int NUM_CONSOLES      = 4;
  localparam int CELLS_PER_CONSOLE = 4096;
  localparam int LINE_WIDTH        = 80;
  localparam int WINDOW_CELLS      = 2000;

  // Port widths fixed by the interface
  localparam int OUT_W     = 14;
  localparam int CONSOLE_W = 3;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 3;

  localparam int CON_W  = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
  localparam int CELL_W = $clog2(NUM_CONSOLES * CELLS_PER_CONSOLE);
  localparam int SUM_W  = $clog2(NUM_CONSOLES * CELLS_PER_CONSOLE + WINDOW_CELLS + LINE_WIDTH) + 1;
  localparam int OFF_W  = $clog2(CELLS_PER_CONSOLE);
  localparam int LW_W   = $clog2(LINE_WIDTH) + 1;

  // Line number of an offset: multiply by a rounded-up reciprocal, then shift
  localparam int RCP_SHIFT = OFF_W + LW_W;
  localparam int PROD_W    = RCP_SHIFT + OFF_W;
  localparam int RCP_INT   = ((2 ** RCP_SHIFT) + LINE_WIDTH - 1) / LINE_WIDTH;

  localparam int GUARD_INT = CELLS_PER_CONSOLE / LINE_WIDTH + 4;
  localparam int GUARD_W   = $clog2(GUARD_INT + 1);

  localparam logic [SUM_W-1:0]        CELLS_S   = SUM_W'(CELLS_PER_CONSOLE);
  localparam logic [SUM_W-1:0]        WIN_S     = SUM_W'(WINDOW_CELLS);
  localparam logic [SUM_W-1:0]        LINE_S    = SUM_W'(LINE_WIDTH);
  localparam logic [SUM_W-1:0]        ONE_S     = SUM_W'(1);
  localparam logic [PROD_W-1:0]       RCP_V     = PROD_W'(RCP_INT);
  localparam logic [OFF_W+LW_W-1:0]   LINE_P    = (OFF_W + LW_W)'(LINE_WIDTH);
  localparam logic [GUARD_W-1:0]      GUARD_V   = GUARD_W'(GUARD_INT);
  localparam logic [CONSOLE_W:0]      CON_LIMIT = (CONSOLE_W + 1)'(NUM_CONSOLES);

  localparam logic [BYTE_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [BYTE_W-1:0] BACKSPACE_CODE = 8'd8;
  localparam logic [BYTE_W-1:0] BLANK_CODE     = 8'h20;
  localparam logic [BYTE_W-1:0] ATTR_RST       = 8'd7;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_DEF   = 3'd0,
    OP_PUT_ATTR  = 3'd1,
    OP_SCROLL_UP = 3'd2,
    OP_SCROLL_DN = 3'd3,
    OP_SELECT    = 3'd4
  } op_e;

  typedef struct packed {
    logic [CELL_W-1:0] win;
    logic [CELL_W-1:0] base;
    logic              up;
  } scroll_req_t;

  function automatic logic [SUM_W-1:0] widen(input logic [CELL_W-1:0] x);
    return {{(SUM_W-CELL_W){1'b0}}, x};
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [CELL_W-1:0] x);
    logic [CELL_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, x};
    return w[OUT_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] slice_base(input int c);
    logic [SUM_W-1:0] b;
    b = SUM_W'(c * CELLS_PER_CONSOLE);
    return b[CELL_W-1:0];
  endfunction

endpackage

// ===== design/text_console_cursor_engine_top.sv =====
// Top level of the text console cursor engine: command sequencer, console state, output register.
// Depends on tcce_pkg and tcce_scroll_unit.
//
// Each command yields exactly one result transfer. Select and scroll commands pass through S_EXEC
// to S_DONE, and rejected commands go straight to S_DONE. A printed character, backspace or newline
// also passes through S_CATCH, where the window steps down after the cursor until it is no longer
// behind, at most CELLS_PER_CONSOLE/LINE_WIDTH+4 steps; a newline first visits S_DIV, S_MUL and S_NL
// unless the cursor lies within LINE_WIDTH cells of the slice end.
// All window movement goes one scroll step per cycle through the single scroll unit; newline finds
// the line start with a reciprocal multiply.
// in_stall_o is high from a command's transfer until its result is loaded into the output
// register, which then holds it while the next command is taken.
module text_console_cursor_engine_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tcce_pkg::OP_W-1:0]        op_i,
  input  logic [tcce_pkg::CONSOLE_W-1:0]   console_i,
  input  logic [tcce_pkg::BYTE_W-1:0]      char_code_i,
  input  logic [tcce_pkg::BYTE_W-1:0]      attr_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             mem_write_o,
  output logic [tcce_pkg::OUT_W-1:0]       mem_addr_o,
  output logic [tcce_pkg::BYTE_W-1:0]      mem_char_o,
  output logic [tcce_pkg::BYTE_W-1:0]      mem_attr_o,
  output logic                             show_update_o,
  output logic [tcce_pkg::OUT_W-1:0]       cursor_out_o,
  output logic [tcce_pkg::OUT_W-1:0]       window_out_o,
  input  logic                             cfg_we_i,
  input  logic [tcce_pkg::BYTE_W-1:0]      cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_NL    = 7'b0010000,
    S_CATCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // console state
  logic [tcce_pkg::CELL_W-1:0] cursor_q [tcce_pkg::NUM_CONSOLES];
  logic [tcce_pkg::CELL_W-1:0] window_q [tcce_pkg::NUM_CONSOLES];
  logic [tcce_pkg::CON_W-1:0]  shown_q, shown_d;
  logic [tcce_pkg::BYTE_W-1:0] dattr_q;

  // working registers of the current command
  tcce_pkg::op_e               op_q, op_d;
  logic [tcce_pkg::CON_W-1:0]  con_q, con_d;
  logic [tcce_pkg::BYTE_W-1:0] ch_q, ch_d;
  logic [tcce_pkg::BYTE_W-1:0] attr_q, attr_d;
  logic [tcce_pkg::CELL_W-1:0] base_q, base_d;
  logic [tcce_pkg::CELL_W-1:0] cur_q, cur_d;
  logic [tcce_pkg::CELL_W-1:0] win_q, win_d;
  logic                        bad_q, bad_d;
  logic [tcce_pkg::GUARD_W-1:0] guard_q, guard_d;
  logic [tcce_pkg::OFF_W-1:0]  line_q, line_d;
  logic [tcce_pkg::OFF_W-1:0]  lstart_q, lstart_d;
  logic                        wr_q, wr_d;
  logic [tcce_pkg::CELL_W-1:0] waddr_q, waddr_d;
  logic [tcce_pkg::BYTE_W-1:0] wch_q, wch_d;
  logic [tcce_pkg::BYTE_W-1:0] wat_q, wat_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        mem_write_q, mem_write_d;
  logic [tcce_pkg::OUT_W-1:0]  mem_addr_q, mem_addr_d;
  logic [tcce_pkg::BYTE_W-1:0] mem_char_q, mem_char_d;
  logic [tcce_pkg::BYTE_W-1:0] mem_attr_q, mem_attr_d;
  logic                        show_q, show_d;
  logic [tcce_pkg::OUT_W-1:0]  cur_out_q, cur_out_d;
  logic [tcce_pkg::OUT_W-1:0]  win_out_q, win_out_d;

  logic                        in_acc;
  logic                        done_fire;
  logic [tcce_pkg::CON_W-1:0]  con_in;
  logic [tcce_pkg::SUM_W-1:0]  off_s;
  logic [tcce_pkg::OFF_W-1:0]  off_n;
  logic [tcce_pkg::PROD_W-1:0] rcp_prod;
  logic [tcce_pkg::OFF_W+tcce_pkg::LW_W-1:0] line_prod;
  logic [tcce_pkg::SUM_W-1:0]  nl_sum;
  logic                        behind;

  tcce_pkg::scroll_req_t       scr_req;
  logic [tcce_pkg::CELL_W-1:0] scr_win;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign con_in    = console_i[tcce_pkg::CON_W-1:0];

  assign off_s     = tcce_pkg::widen(cur_q) - tcce_pkg::widen(base_q);
  assign off_n     = off_s[tcce_pkg::OFF_W-1:0];
  assign rcp_prod  = {{(tcce_pkg::PROD_W-tcce_pkg::OFF_W){1'b0}}, off_n} * tcce_pkg::RCP_V;
  assign line_prod = {{tcce_pkg::LW_W{1'b0}}, line_q} * tcce_pkg::LINE_P;
  assign nl_sum    = tcce_pkg::widen(base_q)
                   + {{(tcce_pkg::SUM_W-tcce_pkg::OFF_W){1'b0}}, lstart_q}
                   + tcce_pkg::LINE_S;
  assign behind    = tcce_pkg::widen(cur_q) >= tcce_pkg::widen(win_q) + tcce_pkg::WIN_S;

  assign scr_req.win  = win_q;
  assign scr_req.base = base_q;
  assign scr_req.up   = (state_q == S_EXEC) && (op_q == tcce_pkg::OP_SCROLL_UP);

  tcce_scroll_unit u_scroll (
    .req_i (scr_req),
    .win_o (scr_win)
  );

  always_comb begin
    state_d     = state_q;
    shown_d     = shown_q;
    op_d        = op_q;
    con_d       = con_q;
    ch_d        = ch_q;
    attr_d      = attr_q;
    base_d      = base_q;
    cur_d       = cur_q;
    win_d       = win_q;
    bad_d       = bad_q;
    guard_d     = guard_q;
    line_d      = line_q;
    lstart_d    = lstart_q;
    wr_d        = wr_q;
    waddr_d     = waddr_q;
    wch_d       = wch_q;
    wat_d       = wat_q;
    out_valid_d = out_valid_q;
    mem_write_d = mem_write_q;
    mem_addr_d  = mem_addr_q;
    mem_char_d  = mem_char_q;
    mem_attr_d  = mem_attr_q;
    show_d      = show_q;
    cur_out_d   = cur_out_q;
    win_out_d   = win_out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = tcce_pkg::op_e'(op_i);
          con_d   = con_in;
          ch_d    = char_code_i;
          attr_d  = attr_i;
          base_d  = tcce_pkg::slice_base(int'(con_in));
          cur_d   = cursor_q[con_in];
          win_d   = window_q[con_in];
          bad_d   = (op_i > tcce_pkg::OP_SELECT) || ({1'b0, console_i} >= tcce_pkg::CON_LIMIT);
          wr_d    = 1'b0;
          waddr_d = '0;
          wch_d   = '0;
          wat_d   = '0;
          state_d = bad_d ? S_DONE : S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          tcce_pkg::OP_SELECT: begin
            shown_d = con_q;
            state_d = S_DONE;
          end
          tcce_pkg::OP_SCROLL_UP, tcce_pkg::OP_SCROLL_DN: begin
            win_d   = scr_win;
            state_d = S_DONE;
          end
          default: begin
            guard_d = tcce_pkg::GUARD_V;
            state_d = S_CATCH;
            if (ch_q == tcce_pkg::NEWLINE_CODE) begin
              // stays put within LINE_WIDTH cells of the slice end
              if (off_s + tcce_pkg::LINE_S < tcce_pkg::CELLS_S) begin
                state_d = S_DIV;
              end
            end else if (ch_q == tcce_pkg::BACKSPACE_CODE) begin
              if (cur_q > base_q) begin
                cur_d   = cur_q - 1'b1;
                wr_d    = 1'b1;
                waddr_d = cur_q - 1'b1;
                wch_d   = tcce_pkg::BLANK_CODE;
                wat_d   = dattr_q;
              end
            end else begin
              wr_d    = 1'b1;
              waddr_d = cur_q;
              wch_d   = ch_q;
              wat_d   = (op_q == tcce_pkg::OP_PUT_DEF) ? dattr_q : attr_q;
              if (off_s + tcce_pkg::ONE_S < tcce_pkg::CELLS_S) begin
                cur_d = cur_q + 1'b1;
              end else begin
                // slice end: cursor wraps past base and the window scrolls once
                cur_d = base_q + 1'b1;
                win_d = scr_win;
              end
            end
          end
        endcase
      end
      S_DIV: begin
        line_d  = rcp_prod[tcce_pkg::RCP_SHIFT +: tcce_pkg::OFF_W];
        state_d = S_MUL;
      end
      S_MUL: begin
        lstart_d = line_prod[tcce_pkg::OFF_W-1:0];
        state_d  = S_NL;
      end
      S_NL: begin
        cur_d   = nl_sum[tcce_pkg::CELL_W-1:0];
        state_d = S_CATCH;
      end
      S_CATCH: begin
        if (behind && (guard_q != '0)) begin
          win_d   = scr_win;
          guard_d = guard_q - 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            mem_write_d = 1'b0;
            mem_addr_d  = '0;
            mem_char_d  = '0;
            mem_attr_d  = '0;
            show_d      = 1'b0;
            cur_out_d   = '0;
            win_out_d   = '0;
          end else begin
            mem_write_d = wr_q;
            mem_addr_d  = tcce_pkg::to_out(waddr_q);
            mem_char_d  = wch_q;
            mem_attr_d  = wat_q;
            show_d      = (con_q == shown_q);
            cur_out_d   = tcce_pkg::to_out(cur_q);
            win_out_d   = tcce_pkg::to_out(win_q);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      shown_q     <= '0;
      dattr_q     <= tcce_pkg::ATTR_RST;
      for (int i = 0; i < tcce_pkg::NUM_CONSOLES; i++) begin
        cursor_q[i] <= tcce_pkg::slice_base(i);
        window_q[i] <= tcce_pkg::slice_base(i);
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      shown_q     <= shown_d;
      if (cfg_we_i) begin
        dattr_q <= cfg_data_i;
      end
      if (done_fire && !bad_q) begin
        cursor_q[con_q] <= cur_q;
        window_q[con_q] <= win_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    con_q       <= con_d;
    ch_q        <= ch_d;
    attr_q      <= attr_d;
    base_q      <= base_d;
    cur_q       <= cur_d;
    win_q       <= win_d;
    bad_q       <= bad_d;
    guard_q     <= guard_d;
    line_q      <= line_d;
    lstart_q    <= lstart_d;
    wr_q        <= wr_d;
    waddr_q     <= waddr_d;
    wch_q       <= wch_d;
    wat_q       <= wat_d;
    mem_write_q <= mem_write_d;
    mem_addr_q  <= mem_addr_d;
    mem_char_q  <= mem_char_d;
    mem_attr_q  <= mem_attr_d;
    show_q      <= show_d;
    cur_out_q   <= cur_out_d;
    win_out_q   <= win_out_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign mem_write_o   = mem_write_q;
  assign mem_addr_o    = mem_addr_q;
  assign mem_char_o    = mem_char_q;
  assign mem_attr_o    = mem_attr_q;
  assign show_update_o = show_q;
  assign cursor_out_o  = cur_out_q;
  assign window_out_o  = win_out_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer idle right after a command transfer");

  a_no_write_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !mem_write_q) |->
      (mem_addr_q == '0) && (mem_char_q == '0) && (mem_attr_q == '0))
    else $error("cell fields nonzero without a cell write");

  a_cursor_in_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CATCH) |->
      (cur_q >= base_q) &&
      (tcce_pkg::widen(cur_q) < tcce_pkg::widen(base_q) + tcce_pkg::CELLS_S))
    else $error("cursor outside its console slice");

  a_window_above_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CATCH) |-> (win_q >= base_q))
    else $error("window start below console base");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished command not presented as a result");
`endif

endmodule

// ===== design/tcce_scroll_unit.sv =====
// One-line window scroll step (up or down) within a console slice.
// Depends on tcce_pkg; shared by every scroll the sequencer performs.
module tcce_scroll_unit (
  input  tcce_pkg::scroll_req_t       req_i,
  output logic [tcce_pkg::CELL_W-1:0] win_o
);

  logic [tcce_pkg::SUM_W-1:0] win_w;
  logic [tcce_pkg::SUM_W-1:0] base_w;
  logic [tcce_pkg::SUM_W-1:0] nxt_w;

  always_comb begin
    win_w  = tcce_pkg::widen(req_i.win);
    base_w = tcce_pkg::widen(req_i.base);
    if (req_i.up) begin
      if (win_w > base_w) begin
        if (win_w - base_w >= tcce_pkg::LINE_S) begin
          nxt_w = win_w - tcce_pkg::LINE_S;
        end else begin
          nxt_w = base_w;
        end
      end else begin
        nxt_w = win_w;
      end
    end else begin
      // window wraps to the slice base once its end reaches the slice end
      if (win_w + tcce_pkg::WIN_S < base_w + tcce_pkg::CELLS_S) begin
        nxt_w = win_w + tcce_pkg::LINE_S;
      end else begin
        nxt_w = base_w;
      end
    end
    win_o = nxt_w[tcce_pkg::CELL_W-1:0];
  end

endmodule
